// ===== sv/assert_macros.svh =====
// assertion macros shared by the interpolator modules
// expects clk and arst_n in the scope of every use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define LPI_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// implication form, antecedent and consequent in the same cycle
`define LPI_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ===== sv/lpi_pkg.sv =====
// shared widths, register codes, reset table and stage types
// used by every module of the level to permille interpolator
package lpi_pkg;

	localparam int TABLE_POINTS = 6;
	localparam int REG_POINTS   = 6;
	localparam int USED_POINTS  = (TABLE_POINTS < 2) ? 2 :
		((TABLE_POINTS > REG_POINTS) ? REG_POINTS : TABLE_POINTS);

	localparam int DIST_W  = 16;
	localparam int OFS_W   = 10;
	localparam int LUT_W   = 20;
	localparam int PERM_W  = 10;
	localparam int FRAC_W  = 4;
	localparam int HQ_W    = (LUT_W - PERM_W) + FRAC_W;
	localparam int OFSQ_W  = OFS_W + FRAC_W;
	localparam int D_W     = DIST_W + 1;
	localparam int PROD_W  = PERM_W + HQ_W;
	localparam int DIVD_W  = PROD_W + 1;
	localparam int DSH_W   = HQ_W + PERM_W;
	localparam int LATENCY = 4 + PERM_W;

	localparam int CFG_IDX_W  = $clog2(REG_POINTS + 1);
	localparam int CFG_DATA_W = (LUT_W > OFS_W) ? LUT_W : OFS_W;

	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_LUT_BASE = CFG_IDX_W'(1);

	// clamped results run through the divider as p * 16 / 16
	localparam logic [HQ_W-1:0] CLAMP_W = HQ_W'(16);

	localparam logic [LUT_W-1:0] LUT_RESET [REG_POINTS] = '{
		LUT_W'(1000), LUT_W'(21280), LUT_W'(41560),
		LUT_W'(61840), LUT_W'(82120), LUT_W'(102400)
	};

	typedef struct packed {
		logic              valid;
		logic [PERM_W-1:0] p0;
		logic [PERM_W-1:0] p1;
		logic [HQ_W-1:0]   w;
		logic [HQ_W-1:0]   t;
	} seg_t;

	typedef struct packed {
		logic              valid;
		logic [DIVD_W-1:0] rem;
		logic [DSH_W-1:0]  dsh;
		logic [PERM_W-1:0] quo;
	} div_t;

endpackage

// ===== sv/lpi_seg.sv =====
// depth offset and segment selection, two pipeline stages
// depends on lpi_pkg and assert_macros.svh
`include "assert_macros.svh"

module lpi_seg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [lpi_pkg::DIST_W-1:0]        distance_q4,
	input  logic [lpi_pkg::OFS_W-1:0]         tank_offset,
	input  logic [lpi_pkg::LUT_W-1:0]         lut [lpi_pkg::REG_POINTS],
	output lpi_pkg::seg_t                     seg
);

	logic                               valid_s1;
	logic signed [lpi_pkg::D_W-1:0]     d_s1;
	logic signed [lpi_pkg::D_W-1:0]     d_calc;
	logic signed [lpi_pkg::D_W-1:0]     hd [lpi_pkg::REG_POINTS];
	logic [lpi_pkg::PERM_W-1:0]         pm [lpi_pkg::REG_POINTS];
	logic signed [lpi_pkg::D_W-1:0]     h0_sel;
	logic signed [lpi_pkg::D_W-1:0]     h1_sel;
	logic signed [lpi_pkg::D_W-1:0]     t_full;
	logic signed [lpi_pkg::D_W-1:0]     w_full;
	logic [lpi_pkg::PERM_W-1:0]         p0_sel;
	logic [lpi_pkg::PERM_W-1:0]         p1_sel;
	lpi_pkg::seg_t                      seg_d;
	logic                               valid_s2;
	logic [lpi_pkg::PERM_W-1:0]         p0_s2;
	logic [lpi_pkg::PERM_W-1:0]         p1_s2;
	logic [lpi_pkg::HQ_W-1:0]           w_s2;
	logic [lpi_pkg::HQ_W-1:0]           t_s2;

	assign d_calc = $signed({1'b0, distance_q4})
		- $signed({{(lpi_pkg::D_W - lpi_pkg::OFSQ_W){1'b0}}, tank_offset,
			{lpi_pkg::FRAC_W{1'b0}}});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		d_s1 <= d_calc;
	end

	// table depths in 1/16 cm
	always_comb begin
		for (int k = 0; k < lpi_pkg::REG_POINTS; k++) begin
			hd[k] = $signed({{(lpi_pkg::D_W - lpi_pkg::HQ_W){1'b0}},
				lut[k][lpi_pkg::LUT_W-1:lpi_pkg::PERM_W], {lpi_pkg::FRAC_W{1'b0}}});
			pm[k] = lut[k][lpi_pkg::PERM_W-1:0];
		end
	end

	// first segment whose upper depth bounds d
	always_comb begin
		h0_sel = hd[0];
		h1_sel = hd[1];
		p0_sel = pm[0];
		p1_sel = pm[1];
		for (int k = lpi_pkg::USED_POINTS - 2; k >= 0; k--) begin
			if (d_s1 <= hd[k+1]) begin
				h0_sel = hd[k];
				h1_sel = hd[k+1];
				p0_sel = pm[k];
				p1_sel = pm[k+1];
			end
		end
	end

	assign t_full = d_s1 - h0_sel;
	assign w_full = h1_sel - h0_sel;

	always_comb begin
		seg_d.valid = valid_s1;
		if (d_s1 <= hd[0]) begin
			seg_d.p0 = pm[0];
			seg_d.p1 = pm[0];
			seg_d.w  = lpi_pkg::CLAMP_W;
			seg_d.t  = '0;
		end else if (d_s1 >= hd[lpi_pkg::USED_POINTS-1]) begin
			seg_d.p0 = pm[lpi_pkg::USED_POINTS-1];
			seg_d.p1 = pm[lpi_pkg::USED_POINTS-1];
			seg_d.w  = lpi_pkg::CLAMP_W;
			seg_d.t  = '0;
		end else begin
			seg_d.p0 = p0_sel;
			seg_d.p1 = p1_sel;
			seg_d.w  = w_full[lpi_pkg::HQ_W-1:0];
			seg_d.t  = t_full[lpi_pkg::HQ_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= seg_d.valid;
		end
	end

	always_ff @(posedge clk) begin
		p0_s2 <= seg_d.p0;
		p1_s2 <= seg_d.p1;
		w_s2  <= seg_d.w;
		t_s2  <= seg_d.t;
	end

	assign seg = '{valid: valid_s2, p0: p0_s2, p1: p1_s2, w: w_s2, t: t_s2};

	`LPI_ASSERT_IMP(a_seg_width, valid_s2, (w_s2 != '0) && (t_s2 <= w_s2),
		"segment width zero or offset outside segment")

endmodule

// ===== sv/lpi_num.sv =====
// weighted sum of the two segment ends and divider set-up, two stages
// depends on lpi_pkg
module lpi_num (
	input  logic          clk,
	input  logic          arst_n,
	input  lpi_pkg::seg_t seg,
	output lpi_pkg::div_t div
);

	logic                        valid_s3;
	logic [lpi_pkg::PROD_W-1:0]  prod0_s3;
	logic [lpi_pkg::PROD_W-1:0]  prod1_s3;
	logic [lpi_pkg::HQ_W-1:0]    w_s3;
	logic [lpi_pkg::HQ_W-1:0]    wt;
	logic [lpi_pkg::DIVD_W-1:0]  num;
	logic [lpi_pkg::DIVD_W-1:0]  divd;
	logic                        valid_s4;
	logic [lpi_pkg::DIVD_W-1:0]  rem_s4;
	logic [lpi_pkg::DSH_W-1:0]   dsh_s4;

	assign wt = seg.w - seg.t;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s3 <= seg.valid;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		prod0_s3 <= lpi_pkg::PROD_W'(seg.p0 * wt);
		prod1_s3 <= lpi_pkg::PROD_W'(seg.p1 * seg.t);
		w_s3     <= seg.w;
	end

	// rounding half up: (2 * num + w) / (2 * w)
	assign num  = {1'b0, prod0_s3} + {1'b0, prod1_s3};
	assign divd = {num[lpi_pkg::DIVD_W-2:0], 1'b0}
		+ {{(lpi_pkg::DIVD_W - lpi_pkg::HQ_W){1'b0}}, w_s3};

	always_ff @(posedge clk) begin
		rem_s4 <= divd;
		dsh_s4 <= {w_s3, {lpi_pkg::PERM_W{1'b0}}};
	end

	assign div = '{valid: valid_s4, rem: rem_s4, dsh: dsh_s4, quo: '0};

endmodule

// ===== sv/lpi_div_cell.sv =====
// one restoring-division cell: settles one quotient bit per request
// depends on lpi_pkg and assert_macros.svh
`include "assert_macros.svh"

module lpi_div_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  lpi_pkg::div_t din,
	output lpi_pkg::div_t dout
);

	logic                        ge;
	logic [lpi_pkg::DIVD_W-1:0]  dsh_ext;
	logic                        valid_q;
	logic [lpi_pkg::DIVD_W-1:0]  rem_q;
	logic [lpi_pkg::DSH_W-1:0]   dsh_q;
	logic [lpi_pkg::PERM_W-1:0]  quo_q;

	assign dsh_ext = {{(lpi_pkg::DIVD_W - lpi_pkg::DSH_W){1'b0}}, din.dsh};
	assign ge      = din.rem >= dsh_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= din.valid;
		end
	end

	always_ff @(posedge clk) begin
		rem_q <= ge ? (din.rem - dsh_ext) : din.rem;
		dsh_q <= din.dsh >> 1;
		quo_q <= {din.quo[lpi_pkg::PERM_W-2:0], ge};
	end

	assign dout = '{valid: valid_q, rem: rem_q, dsh: dsh_q, quo: quo_q};

	`LPI_ASSERT_IMP(a_cell_bound, din.valid,
		din.rem < {din.dsh[lpi_pkg::DSH_W-2:0], 1'b0} || din.dsh[lpi_pkg::DSH_W-1],
		"partial remainder exceeds two divisor steps")

endmodule

// ===== sv/level_to_permille_interpolator_top.sv =====
// top level: configuration registers, front stages and the divider chain
// depends on lpi_pkg, lpi_seg, lpi_num, lpi_div_cell and assert_macros.svh
`include "assert_macros.svh"

// Takes one distance request on every clock cycle and never holds one off:
// busy stays low. Each request yields exactly one fill_permille, shown with
// done for a single cycle; the receiver must take it then, as results cannot
// be stalled. The pipeline is four front stages (depth, segment pick,
// products, divider set-up) and a chain of ten division cells, one per
// quotient bit, each passing its partial remainder to the next cell every
// cycle. Configuration writes land at once and must only be made while no
// request is in flight.
module level_to_permille_interpolator_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [lpi_pkg::DIST_W-1:0]         distance_q4,
	output logic                               done,
	output logic [lpi_pkg::PERM_W-1:0]         fill_permille,
	input  logic                               cfg_wen,
	input  logic [lpi_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [lpi_pkg::CFG_DATA_W-1:0]     cfg_data
);

	logic [lpi_pkg::OFS_W-1:0]  tank_offset_q;
	logic [lpi_pkg::LUT_W-1:0]  lut_q [lpi_pkg::REG_POINTS];
	lpi_pkg::seg_t              seg;
	lpi_pkg::div_t              chain [lpi_pkg::PERM_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tank_offset_q <= '0;
			for (int k = 0; k < lpi_pkg::REG_POINTS; k++) begin
				lut_q[k] <= lpi_pkg::LUT_RESET[k];
			end
		end else if (cfg_wen) begin
			if (cfg_index == lpi_pkg::CFG_OFFSET) begin
				tank_offset_q <= cfg_data[lpi_pkg::OFS_W-1:0];
			end
			for (int k = 0; k < lpi_pkg::REG_POINTS; k++) begin
				if (cfg_index == lpi_pkg::CFG_LUT_BASE + lpi_pkg::CFG_IDX_W'(k)) begin
					lut_q[k] <= cfg_data[lpi_pkg::LUT_W-1:0];
				end
			end
		end
	end

	assign busy = 1'b0;

	lpi_seg u_seg (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.distance_q4 (distance_q4),
		.tank_offset (tank_offset_q),
		.lut         (lut_q),
		.seg         (seg)
	);

	lpi_num u_num (
		.clk    (clk),
		.arst_n (arst_n),
		.seg    (seg),
		.div    (chain[0])
	);

	for (genvar g = 0; g < lpi_pkg::PERM_W; g++) begin : g_cell
		lpi_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.din    (chain[g]),
			.dout   (chain[g+1])
		);
	end

	assign done          = chain[lpi_pkg::PERM_W].valid;
	assign fill_permille = chain[lpi_pkg::PERM_W].quo;

	`LPI_ASSERT(a_req_to_result, start |-> ##(lpi_pkg::LATENCY) done,
		"request did not yield a result on time")
	`LPI_ASSERT_IMP(a_result_from_req, done, $past(start, lpi_pkg::LATENCY),
		"result without a matching request")
	`LPI_ASSERT_IMP(a_final_rem, done,
		chain[lpi_pkg::PERM_W].rem < {chain[lpi_pkg::PERM_W].dsh, 1'b0},
		"final remainder not below divisor")

endmodule

// ===== verif/tb_level_to_permille_interpolator_top.sv =====
// testbench for level_to_permille_interpolator_top: directed table, then random requests
// over many table settings, each result checked against a typed value or a fixed-point interpolation predictor
// depends on lpi_pkg and the rtl of the interpolator
`timescale 1ns / 1ps

module tb_level_to_permille_interpolator_top;

	localparam logic [lpi_pkg::CFG_IDX_W-1:0] CFG_IDX_UNUSED =
		lpi_pkg::CFG_IDX_W'(lpi_pkg::REG_POINTS + 1);
	localparam int DRAIN_LIMIT = 1000;
	localparam int DIR_ROWS = 24;

	typedef enum int {
		TBL_RISING, TBL_HIGH_PERM, TBL_SCRAMBLED, TBL_EXTREMES, TBL_DEFAULT, TBL_NARROW
	} table_kind_t;

	typedef struct packed {
		logic [lpi_pkg::DIST_W-1:0] dist_q4;
		logic                       typed;
		logic [lpi_pkg::PERM_W-1:0] fill;
	} dir_row_t;

	typedef struct packed {
		logic [lpi_pkg::DIST_W-1:0] dist_q4;
		logic [lpi_pkg::PERM_W-1:0] fill;
	} fill_expect_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           start = 1'b0;
	logic                           busy;
	logic [lpi_pkg::DIST_W-1:0]     distance_q4 = '0;
	logic                           done;
	logic [lpi_pkg::PERM_W-1:0]     fill_permille;
	logic                           cfg_wen = 1'b0;
	logic [lpi_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [lpi_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	logic [lpi_pkg::OFS_W-1:0] ofs_setting;
	logic [lpi_pkg::LUT_W-1:0] lut_setting [lpi_pkg::REG_POINTS];
	fill_expect_t              pending_fills [$];
	fill_expect_t              head;
	int                        errors = 0;
	int                        idle_pct = 0;

	dir_row_t directed_rows [DIR_ROWS] = '{
		'{16'd0,     1'b1, 10'd1000},
		'{16'd1600,  1'b1, 10'd0},
		'{16'd65535, 1'b1, 10'd0},
		'{16'd320,   1'b1, 10'd800},
		'{16'd160,   1'b1, 10'd900},
		'{16'd800,   1'b1, 10'd500},
		'{16'd640,   1'b1, 10'd600},
		'{16'd960,   1'b1, 10'd400},
		'{16'd1280,  1'b1, 10'd200},
		'{16'd1601,  1'b1, 10'd0},
		'{16'h8000,  1'b1, 10'd0},
		'{16'h7fff,  1'b1, 10'd0},
		'{16'h5555,  1'b1, 10'd0},
		'{16'haaaa,  1'b1, 10'd0},
		'{16'hfffe,  1'b1, 10'd0},
		'{16'd1,     1'b0, 10'd0},
		'{16'd2,     1'b0, 10'd0},
		'{16'd4,     1'b0, 10'd0},
		'{16'd12,    1'b0, 10'd0},
		'{16'd319,   1'b0, 10'd0},
		'{16'd321,   1'b0, 10'd0},
		'{16'd641,   1'b0, 10'd0},
		'{16'd1281,  1'b0, 10'd0},
		'{16'd1599,  1'b0, 10'd0}
	};

	level_to_permille_interpolator_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.distance_q4  (distance_q4),
		.done         (done),
		.fill_permille(fill_permille),
		.cfg_wen      (cfg_wen),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint point_depth_q4(input int k);
		return longint'(lut_setting[k][lpi_pkg::LUT_W-1:lpi_pkg::PERM_W]) * 16;
	endfunction

	function automatic longint point_perm(input int k);
		return longint'(lut_setting[k][lpi_pkg::PERM_W-1:0]);
	endfunction

	function automatic logic [lpi_pkg::PERM_W-1:0] predict_fill(
		input logic [lpi_pkg::DIST_W-1:0] dist_q4);
		longint depth;
		longint h0;
		longint h1;
		longint p0;
		longint p1;
		longint w;
		longint num;
		longint res;
		bit     found;
		depth = longint'(dist_q4) - 16 * longint'(ofs_setting);
		res = 0;
		found = 1'b0;
		if (depth <= point_depth_q4(0)) begin
			res = point_perm(0);
		end else if (depth >= point_depth_q4(lpi_pkg::USED_POINTS - 1)) begin
			res = point_perm(lpi_pkg::USED_POINTS - 1);
		end else begin
			for (int k = 0; k < lpi_pkg::USED_POINTS - 1; k++) begin
				h1 = point_depth_q4(k + 1);
				if (!found && depth <= h1) begin
					found = 1'b1;
					h0 = point_depth_q4(k);
					p0 = point_perm(k);
					p1 = point_perm(k + 1);
					w = h1 - h0;
					if (w <= 0) begin
						res = p1;
					end else begin
						num = p0 * w + (p1 - p0) * (depth - h0);
						if (num < 0)
							num = 0;
						res = (2 * num + w) / (2 * w);
					end
				end
			end
		end
		return lpi_pkg::PERM_W'(res);
	endfunction

	// result check, oldest expectation first
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_fills.size() == 0) begin
				$display("%0t: unexpected fill_permille %0d", $time, fill_permille);
				errors++;
			end else begin
				head = pending_fills.pop_front();
				if (fill_permille !== head.fill) begin
					$display("%0t: distance %0d fill_permille expected %0d actual %0d",
						$time, head.dist_q4, head.fill, fill_permille);
					errors++;
				end
			end
		end
	end

	task automatic push_request(input logic [lpi_pkg::DIST_W-1:0] dist_q4, input logic typed,
		input logic [lpi_pkg::PERM_W-1:0] typed_fill);
		fill_expect_t item;
		item.dist_q4 = dist_q4;
		item.fill = typed ? typed_fill : predict_fill(dist_q4);
		start <= 1'b1;
		distance_q4 <= dist_q4;
		do @(posedge clk); while (busy);
		pending_fills.push_back(item);
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			distance_q4 <= lpi_pkg::DIST_W'($urandom_range(0, 65535));
			@(posedge clk);
		end
	endtask

	task automatic drain_results();
		int waited;
		waited = 0;
		start <= 1'b0;
		while (pending_fills.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (lpi_pkg::LATENCY + 4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [lpi_pkg::CFG_IDX_W-1:0] idx,
		input logic [lpi_pkg::CFG_DATA_W-1:0] data);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		if (idx == lpi_pkg::CFG_OFFSET)
			ofs_setting = data[lpi_pkg::OFS_W-1:0];
		else if (idx >= lpi_pkg::CFG_LUT_BASE
			&& idx < lpi_pkg::CFG_LUT_BASE + lpi_pkg::REG_POINTS)
			lut_setting[idx - lpi_pkg::CFG_LUT_BASE] = data[lpi_pkg::LUT_W-1:0];
	endtask

	function automatic logic [lpi_pkg::OFS_W-1:0] pick_offset();
		case ($urandom_range(0, 3))
			0: return '0;
			1: return '1;
			default: return lpi_pkg::OFS_W'($urandom_range(0, 1023));
		endcase
	endfunction

	task automatic load_table(input table_kind_t kind);
		logic [lpi_pkg::LUT_W-1:0] words [lpi_pkg::REG_POINTS];
		logic [lpi_pkg::OFS_W-1:0] ofs;
		int                        h;
		int                        perm;
		ofs = pick_offset();
		h = (kind == TBL_NARROW) ? $urandom_range(0, 5) : $urandom_range(0, 100);
		for (int k = 0; k < lpi_pkg::REG_POINTS; k++) begin
			case (kind)
				TBL_HIGH_PERM: perm = $urandom_range(0, 1) ? $urandom_range(990, 1023) :
					$urandom_range(0, 1023);
				TBL_SCRAMBLED: perm = 0;
				default:       perm = $urandom_range(0, 1000);
			endcase
			case (kind)
				TBL_SCRAMBLED: words[k] = lpi_pkg::LUT_W'($urandom_range(0, 1048575));
				TBL_EXTREMES: begin
					case ($urandom_range(0, 3))
						0: words[k] = '0;
						1: words[k] = '1;
						2: words[k] = {{(lpi_pkg::LUT_W-lpi_pkg::PERM_W){1'b1}},
							{lpi_pkg::PERM_W{1'b0}}};
						default: words[k] = {{(lpi_pkg::LUT_W-lpi_pkg::PERM_W){1'b0}},
							{lpi_pkg::PERM_W{1'b1}}};
					endcase
				end
				TBL_DEFAULT: words[k] = lpi_pkg::LUT_RESET[k];
				default: words[k] = {10'(h), 10'(perm)};
			endcase
			h += (kind == TBL_NARROW) ? $urandom_range(1, 2) : $urandom_range(1, 200);
			if (h > 1023)
				h = 1023;
		end
		if (kind == TBL_DEFAULT)
			ofs = '0;
		else if (kind == TBL_EXTREMES)
			ofs = $urandom_range(0, 1) ? '1 : '0;
		write_reg(lpi_pkg::CFG_OFFSET, lpi_pkg::CFG_DATA_W'(ofs));
		for (int k = 0; k < lpi_pkg::REG_POINTS; k++)
			write_reg(lpi_pkg::CFG_LUT_BASE + lpi_pkg::CFG_IDX_W'(k), words[k]);
		if (kind == TBL_SCRAMBLED || $urandom_range(0, 3) == 0)
			write_reg(CFG_IDX_UNUSED, lpi_pkg::CFG_DATA_W'($urandom_range(0, 1048575)));
		cfg_wen <= 1'b0;
	endtask

	function automatic logic [lpi_pkg::DIST_W-1:0] pick_distance();
		int hmax;
		int v;
		int k;
		hmax = 0;
		for (int j = 0; j < lpi_pkg::USED_POINTS; j++)
			if (int'(lut_setting[j][lpi_pkg::LUT_W-1:lpi_pkg::PERM_W]) > hmax)
				hmax = int'(lut_setting[j][lpi_pkg::LUT_W-1:lpi_pkg::PERM_W]);
		v = $urandom_range(0, 99);
		if (v < 20) begin
			v = $urandom_range(0, 65535);
		end else if (v < 45) begin
			k = $urandom_range(0, lpi_pkg::USED_POINTS - 1);
			v = 16 * (int'(ofs_setting)
				+ int'(lut_setting[k][lpi_pkg::LUT_W-1:lpi_pkg::PERM_W]))
				+ $urandom_range(0, 4) - 2;
		end else begin
			v = 16 * int'(ofs_setting) + $urandom_range(0, 16 * hmax + 32) - 16;
		end
		if (v < 0)
			v = 0;
		if (v > 65535)
			v = 65535;
		return lpi_pkg::DIST_W'(v);
	endfunction

	initial begin
		int phase;
		int stage_idle [3];
		stage_idle = '{27, 75, 0};
		phase = 0;
		ofs_setting = '0;
		for (int k = 0; k < lpi_pkg::REG_POINTS; k++)
			lut_setting[k] = lpi_pkg::LUT_RESET[k];
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idle_pct = 0;
		for (int r = 0; r < DIR_ROWS; r++)
			push_request(directed_rows[r].dist_q4, directed_rows[r].typed,
				directed_rows[r].fill);
		drain_results();

		for (int s = 0; s < 3; s++) begin
			idle_pct = stage_idle[s];
			for (int p = 0; p < 9; p++) begin
				if (phase < 6)
					load_table(table_kind_t'(phase));
				else
					load_table(table_kind_t'($urandom_range(0, 5)));
				phase++;
				repeat (50)
					push_request(pick_distance(), 1'b0, '0);
				drain_results();
			end
		end

		if (pending_fills.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, pending_fills.size());
			errors++;
		end
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#5ms;
		$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+sv
sv/lpi_pkg.sv
sv/lpi_seg.sv
sv/lpi_num.sv
sv/lpi_div_cell.sv
sv/level_to_permille_interpolator_top.sv
verif/tb_level_to_permille_interpolator_top.sv
